### design/ptd_pkg.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ptd_pkg
// Shared types, constants and the microcode program of the trial-division
// primality tester.
// -----------------------------------------------------------------------------
package ptd_pkg;

	localparam int NUM_BITS_DEF = 31;

	// Arithmetic constants of the 6k +/- 1 wheel
	localparam int SMALLEST_PRIME    = 2;
	localparam int FIRST_ODD_PRIME   = 3;
	localparam int TRIAL_START       = 5;
	localparam int WHEEL_STEP        = 6;
	localparam int PAIR_OFFSET       = 2;
	localparam int SMALL_PRIME_LIMIT = 9;

	localparam int PC_W = 5;

	// Datapath operations, one per control word
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,
		OP_DIVC,
		OP_DIVC2,
		OP_ADD6,
		OP_EMIT1,
		OP_EMIT0
	} op_t;

	// Jump conditions; a true condition loads the target, else advance
	typedef enum logic [3:0] {
		C_NEXT,
		C_ALWAYS,
		C_IN_NONE,
		C_N_LE1,
		C_N_EQ2,
		C_N_EVEN,
		C_N_LT9,
		C_N_DIV3,
		C_REM_ZERO,
		C_Q_LT_C,
		C_DIV_BUSY,
		C_OUT_BLOCKED
	} cond_t;

	typedef struct packed {
		op_t              op;
		cond_t            cond;
		logic [PC_W-1:0]  target;
	} ucode_t;

	// Datapath status seen by the sequencer
	typedef struct packed {
		logic in_none;
		logic n_le1;
		logic n_eq2;
		logic n_even;
		logic n_lt9;
		logic n_div3;
		logic rem_zero;
		logic q_lt_c;
		logic div_busy;
		logic out_blocked;
	} status_t;

	// Program labels
	localparam logic [PC_W-1:0] L_WAIT   = PC_W'(0);
	localparam logic [PC_W-1:0] L_LOOP   = PC_W'(6);
	localparam logic [PC_W-1:0] L_DIVCW  = PC_W'(7);
	localparam logic [PC_W-1:0] L_DIVC2W = PC_W'(11);
	localparam logic [PC_W-1:0] L_TRUE   = PC_W'(14);
	localparam logic [PC_W-1:0] L_FALSE  = PC_W'(16);

	function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
		ucode_t w;
		unique case (pc)
			PC_W'(0):  w = '{OP_LOAD,  C_IN_NONE,     L_WAIT};
			PC_W'(1):  w = '{OP_NONE,  C_N_LE1,       L_FALSE};
			PC_W'(2):  w = '{OP_NONE,  C_N_EQ2,       L_TRUE};
			PC_W'(3):  w = '{OP_NONE,  C_N_EVEN,      L_FALSE};
			PC_W'(4):  w = '{OP_NONE,  C_N_LT9,       L_TRUE};
			PC_W'(5):  w = '{OP_NONE,  C_N_DIV3,      L_FALSE};
			PC_W'(6):  w = '{OP_DIVC,  C_NEXT,        L_WAIT};
			PC_W'(7):  w = '{OP_NONE,  C_DIV_BUSY,    L_DIVCW};
			PC_W'(8):  w = '{OP_NONE,  C_Q_LT_C,      L_TRUE};
			PC_W'(9):  w = '{OP_NONE,  C_REM_ZERO,    L_FALSE};
			PC_W'(10): w = '{OP_DIVC2, C_NEXT,        L_WAIT};
			PC_W'(11): w = '{OP_NONE,  C_DIV_BUSY,    L_DIVC2W};
			PC_W'(12): w = '{OP_NONE,  C_REM_ZERO,    L_FALSE};
			PC_W'(13): w = '{OP_ADD6,  C_ALWAYS,      L_LOOP};
			PC_W'(14): w = '{OP_EMIT1, C_OUT_BLOCKED, L_TRUE};
			PC_W'(15): w = '{OP_NONE,  C_ALWAYS,      L_WAIT};
			PC_W'(16): w = '{OP_EMIT0, C_OUT_BLOCKED, L_FALSE};
			PC_W'(17): w = '{OP_NONE,  C_ALWAYS,      L_WAIT};
			default:   w = '{OP_NONE,  C_ALWAYS,      L_WAIT};
		endcase
		return w;
	endfunction

endpackage

### design/prime_test_trial_division_core.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// prime_test_trial_division_core
// Primality test by trial division over the 6k +/- 1 wheel, run by a small
// microcoded sequencer over one shared serial divider.
// -----------------------------------------------------------------------------
// Takes one NUM_BITS-bit unsigned number per transfer and returns one
// prime_flag per transfer, in order. Items are handled one at a time:
// number_stall stays high from acceptance until the program has loaded the
// result into the output register and returned to its wait step. Small cases
// (0, 1, 2, even values, odd values below 9) and multiples of 3 are settled
// by compares and a mod-3 residue tree. Every other number runs trial steps
// for c = 5, 11, 17, ... while c*c <= n; each step divides n by c and by
// c + 2 on the serial divider, whose one-bit-per-cycle loop carries most of
// the running time. The bound c*c <= n is taken from the quotient of the
// same n / c division (c <= n / c), so it never overflows. The result sits
// in an output register, so the next number is taken while a finished flag
// still waits.
// -----------------------------------------------------------------------------
module prime_test_trial_division_core #(
	parameter int NUM_BITS = ptd_pkg::NUM_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                number_valid,
	output logic                number_stall,
	input  logic [NUM_BITS-1:0] number,
	output logic                result_valid,
	input  logic                result_stall,
	output logic                prime_flag
);
	import ptd_pkg::*;

	op_t                 op;
	status_t             status;

	logic [NUM_BITS-1:0] n_q;
	logic [NUM_BITS-1:0] c_q;
	logic                out_valid_q;
	logic                flag_q;

	logic                div_start;
	logic [NUM_BITS-1:0] div_divisor;
	logic                div_busy;
	logic [NUM_BITS-1:0] div_quo;
	logic [NUM_BITS-1:0] div_rem;
	logic                out_blocked;
	logic                emit;

	// Sequencer: walks the microprogram, one control word per cycle
	ptd_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.status (status),
		.op     (op)
	);

	// Shared divider: n by c and by c + 2
	ptd_div #(
		.NUM_BITS (NUM_BITS)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (div_start),
		.dividend  (n_q),
		.divisor   (div_divisor),
		.busy      (div_busy),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	// Take a number only at the wait step of the program
	assign number_stall = op != OP_LOAD;

	assign div_start = op == OP_DIVC || op == OP_DIVC2;

	always_comb begin
		unique case (op)
			OP_DIVC2: div_divisor = c_q + NUM_BITS'(PAIR_OFFSET);
			default:  div_divisor = c_q;
		endcase
	end

	// Hold the output while the sink stalls; a new flag waits for a free slot
	assign out_blocked = out_valid_q && result_stall;
	assign emit        = (op == OP_EMIT1 || op == OP_EMIT0) && !out_blocked;

	// Residue of v modulo 3: every base-4 digit is worth 1 mod 3, so add the
	// digits in a balanced tree, then fold the small sum twice
	function automatic logic [1:0] residue3(input logic [63:0] v);
		logic [6:0] acc [32];
		logic [3:0] fold1;
		logic [2:0] fold2;
		for (int i = 0; i < 32; i++) begin
			acc[i] = 7'(v[2*i +: 2]);
		end
		for (int w = 16; w >= 1; w = w >> 1) begin
			for (int i = 0; i < w; i++) begin
				acc[i] = acc[2*i] + acc[2*i+1];
			end
		end
		fold1 = 4'(acc[0][1:0]) + 4'(acc[0][3:2]) + 4'(acc[0][5:4]) + 4'(acc[0][6]);
		fold2 = 3'(fold1[1:0]) + 3'(fold1[3:2]);
		if (fold2 >= 3'(FIRST_ODD_PRIME)) begin
			fold2 = fold2 - 3'(FIRST_ODD_PRIME);
		end
		return fold2[1:0];
	endfunction

	always_comb begin
		status.in_none     = !number_valid;
		status.n_le1       = n_q <= NUM_BITS'(1);
		status.n_eq2       = n_q == NUM_BITS'(SMALLEST_PRIME);
		status.n_even      = !n_q[0];
		status.n_lt9       = n_q < NUM_BITS'(SMALL_PRIME_LIMIT);
		status.n_div3      = residue3(64'(n_q)) == '0;
		status.rem_zero    = div_rem == '0;
		status.q_lt_c      = div_quo < c_q;
		status.div_busy    = div_busy;
		status.out_blocked = out_blocked;
	end

	// Operand registers: load the number, advance the wheel candidate by six
	always_ff @(posedge clk) begin
		if (op == OP_LOAD && number_valid) begin
			n_q <= number;
			c_q <= NUM_BITS'(TRIAL_START);
		end else if (op == OP_ADD6) begin
			c_q <= c_q + NUM_BITS'(WHEEL_STEP);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			flag_q <= op == OP_EMIT1;
		end
	end

	assign result_valid = out_valid_q;
	assign prime_flag   = flag_q;

`ifndef ASSERT_OFF
	// A division is started only when the divider is free
	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	// A new number is never taken while a division is still running
	a_accept_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(number_valid && !number_stall) |-> !div_busy)
		else $error("number accepted during a division");

	// A result appears only after an emit step of the program
	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> ($past(op) == OP_EMIT1 || $past(op) == OP_EMIT0))
		else $error("result raised without an emit step");
`endif

endmodule

### design/ptd_div.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ptd_div
// Restoring serial divider: one quotient bit per cycle, gives quotient and
// remainder once busy has fallen.
// -----------------------------------------------------------------------------
module ptd_div #(
	parameter int NUM_BITS = ptd_pkg::NUM_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [NUM_BITS-1:0] dividend,
	input  logic [NUM_BITS-1:0] divisor,
	output logic                busy,
	output logic [NUM_BITS-1:0] quotient,
	output logic [NUM_BITS-1:0] remainder
);
	import ptd_pkg::*;

	localparam int CW = $clog2(NUM_BITS + 1);

	logic [CW-1:0]       cnt_q;
	logic [NUM_BITS-1:0] rem_q;
	logic [NUM_BITS-1:0] quo_q;
	logic [NUM_BITS-1:0] dvs_q;
	logic [NUM_BITS:0]   trial;
	logic                fits;

	assign trial = {rem_q, quo_q[NUM_BITS-1]};
	assign fits  = trial >= {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CW'(NUM_BITS);
		end else if (busy) begin
			cnt_q <= cnt_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy) begin
			// shift in the next dividend bit, subtract where it fits
			if (fits) begin
				rem_q <= NUM_BITS'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[NUM_BITS-1:0];
			end
			quo_q <= {quo_q[NUM_BITS-2:0], fits};
		end
	end

	assign busy      = cnt_q != '0;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

### design/ptd_seq.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// ptd_seq
// Microcode sequencer: step counter, program ROM and conditional jumps.
// -----------------------------------------------------------------------------
module ptd_seq (
	input  logic            clk,
	input  logic            arst_n,
	input  ptd_pkg::status_t status,
	output ptd_pkg::op_t     op
);
	import ptd_pkg::*;

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_next;
	ucode_t          word;
	logic            take;

	assign word = ucode_rom(pc_q);
	assign op   = word.op;

	always_comb begin
		unique case (word.cond)
			C_NEXT:        take = 1'b0;
			C_ALWAYS:      take = 1'b1;
			C_IN_NONE:     take = status.in_none;
			C_N_LE1:       take = status.n_le1;
			C_N_EQ2:       take = status.n_eq2;
			C_N_EVEN:      take = status.n_even;
			C_N_LT9:       take = status.n_lt9;
			C_N_DIV3:      take = status.n_div3;
			C_REM_ZERO:    take = status.rem_zero;
			C_Q_LT_C:      take = status.q_lt_c;
			C_DIV_BUSY:    take = status.div_busy;
			C_OUT_BLOCKED: take = status.out_blocked;
			default:       take = 1'b1;
		endcase
	end

	always_comb begin
		if (take) begin
			pc_next = word.target;
		end else begin
			pc_next = pc_q + PC_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= L_WAIT;
		end else begin
			pc_q <= pc_next;
		end
	end

endmodule
